### hdl/mads_pkg.sv
// Shared types, widths and constants of the moving-average deviation signal block.
package mads_pkg;

	// Sizes of the window and of the item fields.
	localparam int WINDOW_MAX = 64;
	localparam int PTR_W      = $clog2(WINDOW_MAX);
	localparam int LEN_W      = $clog2(WINDOW_MAX + 1);
	localparam int PRICE_W    = 24;
	localparam int CASH_W     = 40;
	localparam int HOLD_W     = 16;
	localparam int THR_W      = 16;
	localparam int FRAC_W     = 16;
	localparam int SUM_W      = 30;
	localparam int ACTION_W   = 2;

	// Derived datapath widths.
	localparam int SCALED_W = LEN_W + PRICE_W;
	localparam int LIMIT_W  = THR_W + SUM_W;
	localparam int CMP_W    = SCALED_W + FRAC_W;

	// Configuration port.
	localparam int APB_DATA_W = 32;
	localparam int ADDR_W     = 3;
	localparam int WLEN_W     = 7;

	localparam logic [WLEN_W-1:0] WLEN_RESET = 7'd20;
	localparam logic [THR_W-1:0]  THR_RESET  = 16'd1311;

	// Register indexes, taken from the word address.
	typedef enum logic {
		REG_WINDOW_LENGTH = 1'b0,
		REG_DEV_THRESHOLD = 1'b1
	} reg_idx_t;

	// Trading action codes.
	typedef enum logic [ACTION_W-1:0] {
		ACT_NONE = 2'd0,
		ACT_BUY  = 2'd1,
		ACT_SELL = 2'd2
	} action_t;

	// Configuration seen by the datapath.
	typedef struct packed {
		logic [LEN_W-1:0] eff_len;
		logic [THR_W-1:0] threshold;
		logic             restart;
	} cfg_t;

	// Window length as used: zero acts as one, anything above the maximum as the maximum.
	function automatic logic [LEN_W-1:0] eff_length(input logic [WLEN_W-1:0] wlen);
		logic [LEN_W-1:0] n;
		if (wlen == '0) begin
			n = LEN_W'(1);
		end else if (32'(wlen) > WINDOW_MAX) begin
			n = LEN_W'(WINDOW_MAX);
		end else begin
			n = LEN_W'(wlen);
		end
		return n;
	endfunction

endpackage

### hdl/mads_if.sv
// Valid/ready channel interfaces for price ticks and signal reports.
interface mads_tick_if;
	import mads_pkg::*;

	logic                valid;
	logic                ready;
	logic [PRICE_W-1:0]  price;
	logic [CASH_W-1:0]   cash_available;
	logic [HOLD_W-1:0]   holdings_count;

	modport source (output valid, output price, output cash_available,
		output holdings_count, input ready);
	modport sink (input valid, input price, input cash_available,
		input holdings_count, output ready);
endinterface

interface mads_report_if;
	import mads_pkg::*;

	logic                valid;
	logic                ready;
	action_t             action;
	logic                warming;
	logic [SUM_W-1:0]    window_sum;
	logic [LEN_W-1:0]    fill_count;

	modport source (output valid, output action, output warming,
		output window_sum, output fill_count, input ready);
	modport sink (input valid, input action, input warming,
		input window_sum, input fill_count, output ready);
endinterface

### hdl/mads_cfg.sv
// APB configuration registers: window length and deviation threshold.
module mads_cfg (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             psel,
	input  logic                             penable,
	input  logic                             pwrite,
	input  logic [mads_pkg::ADDR_W-1:0]      paddr,
	input  logic [mads_pkg::APB_DATA_W-1:0]  pwdata,
	output logic [mads_pkg::APB_DATA_W-1:0]  prdata,
	output logic                             pready,
	output mads_pkg::cfg_t                   cfg
);
	import mads_pkg::*;

	logic [WLEN_W-1:0] wlen_q;
	logic [LEN_W-1:0]  eff_len_q;
	logic [THR_W-1:0]  thr_q;
	logic              wr_en;
	reg_idx_t          idx;

	// Registers sit at word addresses; the low byte-lane bits are ignored.
	assign idx    = reg_idx_t'(paddr[2]);
	assign pready = 1'b1;
	assign wr_en  = psel && penable && pwrite && pready;

	// Register writes. The effective length is kept ready so the datapath sees no clamp logic.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wlen_q    <= WLEN_RESET;
			eff_len_q <= eff_length(WLEN_RESET);
			thr_q     <= THR_RESET;
		end else if (wr_en) begin
			case (idx)
				REG_WINDOW_LENGTH: begin
					wlen_q    <= pwdata[WLEN_W-1:0];
					eff_len_q <= eff_length(pwdata[WLEN_W-1:0]);
				end
				REG_DEV_THRESHOLD: begin
					thr_q <= pwdata[THR_W-1:0];
				end
				default: begin
				end
			endcase
		end
	end

	// Read back the raw register values.
	always_comb begin
		case (idx)
			REG_WINDOW_LENGTH: prdata = APB_DATA_W'(wlen_q);
			REG_DEV_THRESHOLD: prdata = APB_DATA_W'(thr_q);
			default:           prdata = '0;
		endcase
	end

	// A window length write restarts the warm-up.
	assign cfg.eff_len   = eff_len_q;
	assign cfg.threshold = thr_q;
	assign cfg.restart   = wr_en && (idx == REG_WINDOW_LENGTH);

endmodule

### hdl/mads_ring.sv
// Price ring memory with one write port and one registered read port.
module mads_ring (
	input  logic                          clk,
	input  logic                          wr_en,
	input  logic [mads_pkg::PTR_W-1:0]    wr_addr,
	input  logic [mads_pkg::PRICE_W-1:0]  wr_data,
	input  logic                          rd_en,
	input  logic [mads_pkg::PTR_W-1:0]    rd_addr,
	output logic [mads_pkg::PRICE_W-1:0]  rd_data
);
	import mads_pkg::*;

	logic [PRICE_W-1:0] mem [WINDOW_MAX];

	// Read returns the old contents when both ports hit the same entry.
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule

### hdl/moving_average_deviation_signal.sv
// Top level: a three-stage pipeline with the price ring, running sum and signal decision.
// The block takes one price tick per cycle unless stalled and returns one report per tick,
// in order. At the accept edge the ring is written at the write pointer and the price
// leaving the window is read on the same memory port pair; stage two updates the running sum
// and forms window_length * price; stage three forms threshold * sum and makes the buy/sell
// decision into the output register. Each stage moves on independently, so a stalled report
// only holds the ticks behind it once the pipeline is full. The ring is not cleared after
// reset: the warm-up makes sure no entry is used before it is written. A write to
// window_length restarts the warm-up; configuration must be written only while the block is
// idle (not enforced). APB registers: window_length at 0x0, deviation_threshold at 0x4.
module moving_average_deviation_signal (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             psel,
	input  logic                             penable,
	input  logic                             pwrite,
	input  logic [mads_pkg::ADDR_W-1:0]      paddr,
	input  logic [mads_pkg::APB_DATA_W-1:0]  pwdata,
	output logic [mads_pkg::APB_DATA_W-1:0]  prdata,
	output logic                             pready,
	mads_tick_if.sink                        tick,
	mads_report_if.source                    report
);
	import mads_pkg::*;

	cfg_t cfg;

	// Window state.
	logic [PTR_W-1:0]    wp_q;
	logic [LEN_W-1:0]    filled_q;
	logic [SUM_W-1:0]    sum_q;

	// Stage one.
	logic                v1_q;
	logic [PRICE_W-1:0]  price_s1;
	logic [CASH_W-1:0]   cash_s1;
	logic [HOLD_W-1:0]   hold_s1;
	logic                drop_s1;
	logic                warm_s1;
	logic [LEN_W-1:0]    fill_s1;
	logic [PRICE_W-1:0]  old_price_s1;

	// Stage two.
	logic                v2_q;
	logic [PRICE_W-1:0]  price_s2;
	logic [CASH_W-1:0]   cash_s2;
	logic [HOLD_W-1:0]   hold_s2;
	logic                warm_s2;
	logic [LEN_W-1:0]    fill_s2;
	logic [SUM_W-1:0]    sum_s2;
	logic [SCALED_W-1:0] scaled_s2;

	// Output register.
	logic                ov_q;
	action_t             action_q;
	logic                warm_q;
	logic [SUM_W-1:0]    sum_out_q;
	logic [LEN_W-1:0]    fill_q;

	logic                en_out;
	logic                en_s2;
	logic                en_s1;
	logic                acc_in;
	logic                drop;
	logic [LEN_W-1:0]    filled_next;
	logic [PTR_W-1:0]    old_idx;
	logic [SUM_W-1:0]    sum_next;
	logic [LIMIT_W-1:0]  limit;
	logic [SCALED_W-1:0] sum_ext;
	logic [SCALED_W-1:0] diff;
	logic                exceed;
	action_t             action_next;

	mads_cfg u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	// Each stage advances when the stage after it is empty or advancing.
	assign en_out     = !ov_q || report.ready;
	assign en_s2      = !v2_q || en_out;
	assign en_s1      = !v1_q || en_s2;
	assign tick.ready = en_s1;
	assign acc_in     = tick.valid && en_s1;

	// Fill count and the ring slot of the price leaving the window.
	assign drop        = filled_q >= cfg.eff_len;
	assign filled_next = drop ? cfg.eff_len : filled_q + LEN_W'(1);
	assign old_idx     = wp_q - cfg.eff_len[PTR_W-1:0];

	mads_ring u_ring (
		.clk     (clk),
		.wr_en   (acc_in),
		.wr_addr (wp_q),
		.wr_data (tick.price),
		.rd_en   (acc_in),
		.rd_addr (old_idx),
		.rd_data (old_price_s1)
	);

	// Pointer and fill count move at the accept edge.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q     <= '0;
			filled_q <= '0;
		end else begin
			if (acc_in) begin
				wp_q     <= wp_q + PTR_W'(1);
				filled_q <= filled_next;
			end
			if (cfg.restart) begin
				filled_q <= '0;
			end
		end
	end

	// Stage one: capture the tick alongside the ring read.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v1_q <= 1'b0;
		end else if (en_s1) begin
			v1_q <= acc_in;
		end
	end

	always_ff @(posedge clk) begin
		if (acc_in) begin
			price_s1 <= tick.price;
			cash_s1  <= tick.cash_available;
			hold_s1  <= tick.holdings_count;
			drop_s1  <= drop;
			warm_s1  <= filled_next < cfg.eff_len;
			fill_s1  <= filled_next;
		end
	end

	// Running sum: drop the leaving price when the window was full, add the new one.
	assign sum_next = sum_q - (drop_s1 ? SUM_W'(old_price_s1) : '0) + SUM_W'(price_s1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sum_q <= '0;
			v2_q  <= 1'b0;
		end else begin
			if (en_s2) begin
				v2_q <= v1_q;
				if (v1_q) begin
					sum_q <= sum_next;
				end
			end
			if (cfg.restart) begin
				sum_q <= '0;
			end
		end
	end

	// Stage two: new sum and window_length * price.
	always_ff @(posedge clk) begin
		if (en_s2 && v1_q) begin
			price_s2  <= price_s1;
			cash_s2   <= cash_s1;
			hold_s2   <= hold_s1;
			warm_s2   <= warm_s1;
			fill_s2   <= fill_s1;
			sum_s2    <= sum_next;
			scaled_s2 <= SCALED_W'(cfg.eff_len) * SCALED_W'(price_s1);
		end
	end

	// Stage three: |N*price - sum| * 2^16 against threshold * sum, strictly greater.
	assign limit   = LIMIT_W'(cfg.threshold) * LIMIT_W'(sum_s2);
	assign sum_ext = SCALED_W'(sum_s2);
	assign diff    = (scaled_s2 > sum_ext) ? scaled_s2 - sum_ext : sum_ext - scaled_s2;
	assign exceed  = {diff, FRAC_W'(0)} > CMP_W'(limit);

	always_comb begin
		action_next = ACT_NONE;
		if (!warm_s2 && sum_s2 != '0 && exceed) begin
			if (scaled_s2 < sum_ext && cash_s2 >= CASH_W'(price_s2)) begin
				action_next = ACT_BUY;
			end else if (scaled_s2 > sum_ext && hold_s2 != '0) begin
				action_next = ACT_SELL;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ov_q <= 1'b0;
		end else if (en_out) begin
			ov_q <= v2_q;
		end
	end

	always_ff @(posedge clk) begin
		if (en_out && v2_q) begin
			action_q  <= action_next;
			warm_q    <= warm_s2;
			sum_out_q <= sum_s2;
			fill_q    <= fill_s2;
		end
	end

	// Report transaction.
	assign report.valid      = ov_q;
	assign report.action     = action_q;
	assign report.warming    = warm_q;
	assign report.window_sum = sum_out_q;
	assign report.fill_count = fill_q;

endmodule

### hdl/mads_checker.sv
// Port-level checks on the report channel, bound to the top level.
module mads_checker (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         report_valid,
	input  logic                         report_ready,
	input  mads_pkg::action_t            report_action,
	input  logic                         report_warming,
	input  logic [mads_pkg::SUM_W-1:0]   report_window_sum,
	input  logic [mads_pkg::LEN_W-1:0]   report_fill_count
);
	import mads_pkg::*;

	// No trading signal while the window warms up.
	assert property (@(posedge clk) disable iff (!arst_n)
		report_valid && report_warming |-> report_action == ACT_NONE)
		else $error("signal reported while warming");

	// An empty-valued window never gives a signal.
	assert property (@(posedge clk) disable iff (!arst_n)
		report_valid && report_window_sum == '0 |-> report_action == ACT_NONE)
		else $error("signal reported with zero window sum");

	// Every report follows a tick that was stored, so the window holds at least one price.
	assert property (@(posedge clk) disable iff (!arst_n)
		report_valid |-> report_fill_count != '0 && report_fill_count <= LEN_W'(WINDOW_MAX))
		else $error("fill count out of range");

	// A stalled report holds its contents.
	assert property (@(posedge clk) disable iff (!arst_n)
		report_valid && !report_ready |=> report_valid && $stable(report_window_sum)
			&& $stable(report_action))
		else $error("stalled report changed");

endmodule

bind moving_average_deviation_signal mads_checker u_mads_checker (
	.clk               (clk),
	.arst_n            (arst_n),
	.report_valid      (report.valid),
	.report_ready      (report.ready),
	.report_action     (report.action),
	.report_warming    (report.warming),
	.report_window_sum (report.window_sum),
	.report_fill_count (report.fill_count)
);

### test/moving_average_deviation_signal_tb.sv
// Self-checking testbench for the moving-average deviation signal block.
`timescale 1ns / 1ps

module moving_average_deviation_signal_tb;
	import mads_pkg::*;

	// Reports pass the stage-one, stage-two and output registers after their tick is accepted.
	localparam int LATENCY         = 3;
	localparam int RANDOM_ITEMS    = 800;
	localparam int HOLD_OFF_CYCLES = 150;
	localparam int WATCHDOG_LIMIT  = 1000;

	localparam logic [PRICE_W-1:0] PRICE_MAX = '1;
	localparam logic [CASH_W-1:0]  CASH_MAX  = '1;
	localparam logic [HOLD_W-1:0]  HOLD_MAX  = '1;

	typedef struct packed {
		action_t          action;
		logic             warming;
		logic [SUM_W-1:0] window_sum;
		logic [LEN_W-1:0] fill_count;
	} report_t;

	typedef enum {ROW_TICK, ROW_WRITE} row_kind_t;

	// One row of the directed table: either a register write or a tick.
	typedef struct {
		row_kind_t             kind;
		reg_idx_t              reg_sel;
		logic [APB_DATA_W-1:0] wdata;
		logic [PRICE_W-1:0]    price;
		logic [CASH_W-1:0]     cash;
		logic [HOLD_W-1:0]     holdings;
		bit                    known;
		report_t               result;
	} script_row_t;

	logic                  clk = 1'b0;
	logic                  arst_n;
	logic                  psel;
	logic                  penable;
	logic                  pwrite;
	logic [ADDR_W-1:0]     paddr;
	logic [APB_DATA_W-1:0] pwdata;
	logic [APB_DATA_W-1:0] prdata;
	logic                  pready;

	mads_tick_if   tick_ch ();
	mads_report_if rpt_ch ();

	// Signal predictor state: price history, running sum and configuration.
	logic [PRICE_W-1:0] price_hist [WINDOW_MAX];
	logic [63:0]        win_sum;
	logic [LEN_W-1:0]   win_fill;
	logic [PTR_W-1:0]   wr_ptr;
	logic [WLEN_W-1:0]  wlen_reg;
	logic [THR_W-1:0]   thr_reg;

	report_t     expected_reports [$];
	script_row_t script [$];

	int ticks_sent      = 0;
	int directed_ticks  = 0;
	int reports_checked = 0;
	int buys_seen       = 0;
	int sells_seen      = 0;
	int reg_writes      = 0;
	int mismatches      = 0;
	int quiet_cycles    = 0;
	int burst_left      = 1;
	int gap_max         = 0;
	bit hold_off_req    = 1'b0;

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	moving_average_deviation_signal u_dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.tick    (tick_ch),
		.report  (rpt_ch)
	);

	// Window length as the block uses it: zero means one, above the maximum means the maximum.
	function automatic logic [LEN_W-1:0] window_in_use(input logic [WLEN_W-1:0] wl);
		if (wl == '0) begin
			return LEN_W'(1);
		end
		if (wl > WLEN_W'(WINDOW_MAX)) begin
			return LEN_W'(WINDOW_MAX);
		end
		return LEN_W'(wl);
	endfunction

	// Advance the window by one price and work out the report it produces.
	function automatic report_t predict_tick(input logic [PRICE_W-1:0] price,
		input logic [CASH_W-1:0] cash, input logic [HOLD_W-1:0] holdings);
		report_t          r;
		logic [LEN_W-1:0] n;
		logic [PTR_W-1:0] oldest;
		logic [63:0]      scaled;
		logic [63:0]      limit;
		n = window_in_use(wlen_reg);
		if (win_fill >= n) begin
			// A full window drops the price written n ticks ago.
			oldest = wr_ptr - PTR_W'(n);
			win_sum = win_sum - 64'(price_hist[oldest]);
			win_fill = n;
		end else begin
			win_fill = win_fill + LEN_W'(1);
		end
		price_hist[wr_ptr] = price;
		win_sum = win_sum + 64'(price);
		wr_ptr = wr_ptr + PTR_W'(1);

		r.action = ACT_NONE;
		r.warming = (win_fill < n);
		if (!r.warming && win_sum != 64'd0) begin
			// Compare |n*price - sum| * 2^16 against threshold * sum, strictly.
			scaled = 64'(n) * 64'(price);
			limit = 64'(thr_reg) * win_sum;
			if (scaled < win_sum) begin
				if (((win_sum - scaled) << FRAC_W) > limit && 64'(cash) >= 64'(price)) begin
					r.action = ACT_BUY;
				end
			end else if (scaled > win_sum) begin
				if (((scaled - win_sum) << FRAC_W) > limit && holdings != '0) begin
					r.action = ACT_SELL;
				end
			end
		end
		r.window_sum = win_sum[SUM_W-1:0];
		r.fill_count = win_fill;
		return r;
	endfunction

	function automatic void tick_row(input logic [PRICE_W-1:0] p, input logic [CASH_W-1:0] c,
		input logic [HOLD_W-1:0] h, input bit known, input action_t act, input logic warm,
		input logic [SUM_W-1:0] total, input logic [LEN_W-1:0] fill);
		script_row_t row;
		row.kind = ROW_TICK;
		row.reg_sel = REG_WINDOW_LENGTH;
		row.wdata = '0;
		row.price = p;
		row.cash = c;
		row.holdings = h;
		row.known = known;
		row.result.action = act;
		row.result.warming = warm;
		row.result.window_sum = total;
		row.result.fill_count = fill;
		script.insert(script.size(), row);
	endfunction

	function automatic void write_row(input reg_idx_t sel, input logic [APB_DATA_W-1:0] val);
		script_row_t row;
		row.kind = ROW_WRITE;
		row.reg_sel = sel;
		row.wdata = val;
		row.price = '0;
		row.cash = '0;
		row.holdings = '0;
		row.known = 1'b0;
		row.result = '0;
		script.insert(script.size(), row);
	endfunction

	function automatic void check_field(input string what, input logic [63:0] want,
		input logic [63:0] got);
		if (got !== want) begin
			mismatches++;
			$display("%0t: %s mismatch, expected %0d, got %0d", $time, what, want, got);
		end
	endfunction

	// Stop offering ticks and let every outstanding report come back.
	task automatic wait_drained();
		tick_ch.valid <= 1'b0;
		while (expected_reports.size() != 0) begin
			@(posedge clk);
		end
		repeat (LATENCY + 2) @(posedge clk);
	endtask

	// Register write over APB, only ever issued with the block idle.
	task automatic apb_write(input reg_idx_t sel, input logic [APB_DATA_W-1:0] val);
		wait_drained();
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {sel, 2'b00};
		pwdata <= val;
		@(posedge clk);
		penable <= 1'b1;
		do begin
			@(posedge clk);
		end while (pready !== 1'b1);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		if (sel == REG_WINDOW_LENGTH) begin
			// A new window length restarts the warm-up.
			wlen_reg = val[WLEN_W-1:0];
			win_sum = '0;
			win_fill = '0;
		end else begin
			thr_reg = val[THR_W-1:0];
		end
		reg_writes++;
	endtask

	// Offer one tick, record its expected report, then maybe idle between bursts.
	task automatic send_tick(input logic [PRICE_W-1:0] p, input logic [CASH_W-1:0] c,
		input logic [HOLD_W-1:0] h, input bit known, input report_t known_result);
		report_t predicted;
		int      gap;
		tick_ch.valid <= 1'b1;
		tick_ch.price <= p;
		tick_ch.cash_available <= c;
		tick_ch.holdings_count <= h;
		do begin
			@(posedge clk);
		end while (tick_ch.ready !== 1'b1);
		predicted = predict_tick(p, c, h);
		expected_reports.insert(expected_reports.size(), known ? known_result : predicted);
		ticks_sent++;
		burst_left--;
		if (burst_left <= 0) begin
			burst_left = $urandom_range(1, 24);
			gap = (gap_max > 0) ? $urandom_range(0, gap_max) : 0;
			if (gap > 0) begin
				tick_ch.valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
	endtask

	// Report receiver: its own stall pattern, plus a long hold-off on request.
	initial begin
		int rx_mode;
		int rx_left;
		int rx_count;
		rx_mode = 0;
		rx_left = 0;
		rx_count = 0;
		rpt_ch.ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (hold_off_req) begin
				rpt_ch.ready <= 1'b0;
				repeat (HOLD_OFF_CYCLES - 1) @(posedge clk);
				hold_off_req = 1'b0;
			end else begin
				if (rx_left == 0) begin
					rx_mode = $urandom_range(0, 3);
					rx_left = $urandom_range(20, 200);
				end
				rx_left--;
				rx_count++;
				case (rx_mode)
					0: rpt_ch.ready <= 1'b1;
					1: rpt_ch.ready <= 1'($urandom_range(0, 1));
					2: rpt_ch.ready <= (rx_count % 4 == 0);
					default: rpt_ch.ready <= ($urandom_range(0, 9) != 0);
				endcase
			end
		end
	end

	// Compare each report transaction with the oldest expectation.
	always @(posedge clk) begin
		report_t want;
		if (arst_n === 1'b1 && rpt_ch.valid === 1'b1 && rpt_ch.ready === 1'b1) begin
			if (expected_reports.size() == 0) begin
				mismatches++;
				$display("%0t: report with no tick outstanding, expected none, got sum %0d",
					$time, rpt_ch.window_sum);
			end else begin
				want = expected_reports.pop_front();
				reports_checked++;
				check_field("action", 64'(want.action), 64'(rpt_ch.action));
				check_field("warming", 64'(want.warming), 64'(rpt_ch.warming));
				check_field("window_sum", 64'(want.window_sum), 64'(rpt_ch.window_sum));
				check_field("fill_count", 64'(want.fill_count), 64'(rpt_ch.fill_count));
				if (rpt_ch.action == ACT_BUY) begin
					buys_seen++;
				end else if (rpt_ch.action == ACT_SELL) begin
					sells_seen++;
				end
			end
		end
	end

	// Watchdog: end the run when no transaction of any kind happens for too long.
	always @(posedge clk) begin
		if ((tick_ch.valid === 1'b1 && tick_ch.ready === 1'b1) ||
			(rpt_ch.valid === 1'b1 && rpt_ch.ready === 1'b1) ||
			(psel === 1'b1 && penable === 1'b1)) begin
			quiet_cycles = 0;
		end else begin
			quiet_cycles++;
		end
		if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("%0t: no transaction for %0d cycles", $time, quiet_cycles);
			$display("Simulation FAILED");
			$finish;
		end
	end

	// Stimulus: directed table first, then random phases with varied settings.
	initial begin
		logic [APB_DATA_W-1:0] wl_word;
		logic [APB_DATA_W-1:0] th_word;
		logic [PRICE_W-1:0]    p;
		logic [CASH_W-1:0]     c;
		logic [HOLD_W-1:0]     h;
		int                    phase_len;
		int                    phase_no;
		int                    base;
		int                    spread;
		int                    p_int;
		int                    pick;
		int                    random_ticks;
		bit                    pause_mid;
		bit                    write_len;

		arst_n <= 1'b0;
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		paddr <= '0;
		pwdata <= '0;
		tick_ch.valid <= 1'b0;
		tick_ch.price <= '0;
		tick_ch.cash_available <= '0;
		tick_ch.holdings_count <= '0;
		wlen_reg = WLEN_RESET;
		thr_reg = THR_RESET;
		win_sum = '0;
		win_fill = '0;
		wr_ptr = '0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// First tick after reset only warms the default window.
		tick_row(24'd100, '0, '0, 1'b1, ACT_NONE, 1'b1, 30'd100, 7'd1);
		// One-price window: the price equals the mean, then a zero sum.
		write_row(REG_WINDOW_LENGTH, 32'd1);
		tick_row(PRICE_MAX, CASH_MAX, HOLD_MAX, 1'b1, ACT_NONE, 1'b0, 30'hFFFFFF, 7'd1);
		tick_row('0, '0, '0, 1'b1, ACT_NONE, 1'b0, 30'd0, 7'd1);
		// Length zero behaves as one.
		write_row(REG_WINDOW_LENGTH, 32'd0);
		tick_row(24'd5, CASH_MAX, HOLD_MAX, 1'b1, ACT_NONE, 1'b0, 30'd5, 7'd1);
		// Zero threshold: cash exactly covering, cash short, holdings present and absent.
		write_row(REG_WINDOW_LENGTH, 32'd2);
		write_row(REG_DEV_THRESHOLD, 32'd0);
		tick_row(24'd100, CASH_MAX, 16'd1, 1'b1, ACT_NONE, 1'b1, 30'd100, 7'd1);
		tick_row(24'd50, 40'd50, '0, 1'b1, ACT_BUY, 1'b0, 30'd150, 7'd2);
		tick_row(24'd49, 40'd48, '0, 1'b1, ACT_NONE, 1'b0, 30'd99, 7'd2);
		tick_row(24'd60, '0, 16'd1, 1'b1, ACT_SELL, 1'b0, 30'd109, 7'd2);
		tick_row(24'd70, '0, '0, 1'b1, ACT_NONE, 1'b0, 30'd130, 7'd2);
		// Deviation exactly at one half gives nothing; one step lower threshold fires.
		write_row(REG_DEV_THRESHOLD, 32'd32768);
		write_row(REG_WINDOW_LENGTH, 32'd2);
		tick_row(24'd300, CASH_MAX, '0, 1'b1, ACT_NONE, 1'b1, 30'd300, 7'd1);
		tick_row(24'd100, CASH_MAX, 16'd1, 1'b1, ACT_NONE, 1'b0, 30'd400, 7'd2);
		write_row(REG_DEV_THRESHOLD, 32'd32767);
		tick_row(24'd300, '0, 16'd1, 1'b1, ACT_SELL, 1'b0, 30'd400, 7'd2);
		tick_row(24'd100, CASH_MAX, '0, 1'b1, ACT_BUY, 1'b0, 30'd400, 7'd2);
		// Length above the maximum and the largest threshold.
		write_row(REG_DEV_THRESHOLD, 32'd65535);
		write_row(REG_WINDOW_LENGTH, 32'd127);
		tick_row(PRICE_MAX, CASH_MAX, HOLD_MAX, 1'b1, ACT_NONE, 1'b1, 30'hFFFFFF, 7'd1);
		tick_row('0, '0, '0, 1'b0, ACT_NONE, 1'b0, '0, '0);
		// Short window at the reset threshold.
		write_row(REG_WINDOW_LENGTH, 32'd3);
		write_row(REG_DEV_THRESHOLD, 32'(THR_RESET));
		tick_row(24'd1000, CASH_MAX, 16'd7, 1'b0, ACT_NONE, 1'b0, '0, '0);
		tick_row(24'd1000, CASH_MAX, 16'd7, 1'b0, ACT_NONE, 1'b0, '0, '0);
		tick_row(24'd1000, CASH_MAX, 16'd7, 1'b0, ACT_NONE, 1'b0, '0, '0);
		tick_row(24'd1100, '0, 16'd7, 1'b0, ACT_NONE, 1'b0, '0, '0);
		tick_row(24'd900, CASH_MAX, '0, 1'b0, ACT_NONE, 1'b0, '0, '0);
		tick_row(24'h800000, '0, '0, 1'b0, ACT_NONE, 1'b0, '0, '0);

		gap_max = 3;
		foreach (script[i]) begin
			if (script[i].kind == ROW_WRITE) begin
				apb_write(script[i].reg_sel, script[i].wdata);
			end else begin
				send_tick(script[i].price, script[i].cash, script[i].holdings,
					script[i].known, script[i].result);
			end
		end
		directed_ticks = ticks_sent;

		// Random phases: each picks a window, a threshold, a price level and an idle style.
		phase_no = 0;
		random_ticks = 0;
		while (random_ticks < RANDOM_ITEMS) begin
			write_len = (phase_no == 0) || ($urandom_range(0, 3) != 0);
			case ($urandom_range(0, 7))
				0: wl_word = 32'd1;
				1: wl_word = 32'd2;
				2: wl_word = 32'd64;
				3: wl_word = $urandom_range(3, 16);
				4: wl_word = $urandom_range(17, 63);
				5: wl_word = 32'd0;
				6: wl_word = $urandom_range(65, 127);
				default: wl_word = $urandom;
			endcase
			case ($urandom_range(0, 5))
				0: th_word = 32'd0;
				1: th_word = 32'd65535;
				2, 3: th_word = $urandom_range(0, 4000);
				4: th_word = $urandom_range(0, 65535);
				default: th_word = $urandom;
			endcase
			if (write_len) begin
				apb_write(REG_WINDOW_LENGTH, wl_word);
			end
			apb_write(REG_DEV_THRESHOLD, th_word);
			phase_len = $urandom_range(20, 80);
			if (write_len) begin
				phase_len += int'(window_in_use(wlen_reg));
			end

			gap_max = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 12);
			if (phase_no % 4 == 1) begin
				// Keep offering ticks while the receiver holds off, so the pipeline backs up.
				gap_max = 0;
				hold_off_req = 1'b1;
			end
			pause_mid = ($urandom_range(0, 3) == 0);

			case ($urandom_range(0, 3))
				0: base = $urandom_range(1, 1000);
				1: base = $urandom_range(1000, 1 << 20);
				2: base = $urandom_range(0, int'(PRICE_MAX));
				default: base = int'(PRICE_MAX) - int'($urandom_range(0, 4096));
			endcase
			spread = $urandom_range(2, 12);
			p = PRICE_W'(base);

			for (int i = 0; i < phase_len; i++) begin
				if (pause_mid && i == phase_len / 2) begin
					wait_drained();
				end
				// Mostly prices scattered around the level, with outliers mixed in.
				pick = $urandom_range(0, 19);
				if (pick < 14) begin
					p_int = int'($urandom_range(0, base >> spread));
					p_int = ($urandom_range(0, 1) != 0) ? base + p_int : base - p_int;
					if (p_int < 0) begin
						p_int = 0;
					end
					if (p_int > int'(PRICE_MAX)) begin
						p_int = int'(PRICE_MAX);
					end
					p = PRICE_W'(p_int);
				end else if (pick < 16) begin
					p = PRICE_W'($urandom);
				end else if (pick == 16) begin
					p = '0;
				end else if (pick == 17) begin
					p = PRICE_MAX;
				end
				if ($urandom_range(0, 7) == 0) begin
					base = int'(p);
				end

				case ($urandom_range(0, 9))
					0, 1, 2, 3: c = {8'($urandom), 32'($urandom)};
					4: c = '0;
					5: c = CASH_MAX;
					6, 7: c = CASH_W'(p);
					8: c = CASH_W'(p) - CASH_W'(1);
					default: c = CASH_W'(p) + CASH_W'($urandom_range(0, 1000));
				endcase
				case ($urandom_range(0, 9))
					0, 1, 2, 3: h = '0;
					4, 5, 6, 7: h = HOLD_W'($urandom);
					8: h = HOLD_MAX;
					default: h = 16'd1;
				endcase

				send_tick(p, c, h, 1'b0, '0);
				random_ticks++;
			end
			phase_no++;
		end

		wait_drained();
		$display("Run covered %0d ticks (%0d directed), %0d register writes, %0d phases.",
			ticks_sent, directed_ticks, reg_writes, phase_no);
		$display("Checked %0d reports with %0d buy and %0d sell signals; %0d mismatches.",
			reports_checked, buys_seen, sells_seen, mismatches);
		if (mismatches == 0 && expected_reports.size() == 0) begin
			$display("Simulation PASSED");
		end else begin
			$display("Simulation FAILED");
		end
		$finish;
	end

endmodule
